// ===== design/tpm_pkg.sv =====
// Package for the throttle plausibility monitor.
// Holds widths, check and register codes, shared types and the position compare.
// No dependencies.
`default_nettype none

package tpm_pkg;

  localparam int NOW_W      = 32;
  localparam int POS_W      = 16;
  localparam int OK_W       = 5;
  localparam int THR_W      = 15;
  localparam int NUM_CHECKS = 9;
  localparam int CHK_IDX_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CHK_IDX_W-1:0] CHK_PEDAL_PAIR    = 4'd0;
  localparam logic [CHK_IDX_W-1:0] CHK_THROTTLE_PAIR = 4'd1;
  localparam logic [CHK_IDX_W-1:0] CHK_PEDAL_A_CIRC  = 4'd2;
  localparam logic [CHK_IDX_W-1:0] CHK_PEDAL_B_CIRC  = 4'd3;
  localparam logic [CHK_IDX_W-1:0] CHK_THR_A_CIRC    = 4'd4;
  localparam logic [CHK_IDX_W-1:0] CHK_THR_B_CIRC    = 4'd5;
  localparam logic [CHK_IDX_W-1:0] CHK_TARGET        = 4'd6;
  localparam logic [CHK_IDX_W-1:0] CHK_BRAKE_CIRC    = 4'd7;
  localparam logic [CHK_IDX_W-1:0] CHK_BRAKE_THR     = 4'd8;
  localparam logic [CHK_IDX_W-1:0] CHK_LAST          = CHK_BRAKE_THR;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_SENSOR_LIMIT  = 3'd1,
    CFG_TARGET_LIMIT  = 3'd2,
    CFG_BRAKE_LIMIT   = 3'd3,
    CFG_STARTUP_GRACE = 3'd4,
    CFG_ENABLE_MASK   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]      threshold;
    logic [NOW_W-1:0]      sensor_limit;
    logic [NOW_W-1:0]      target_limit;
    logic [NOW_W-1:0]      brake_limit;
    logic [NOW_W-1:0]      startup_grace;
    logic [NUM_CHECKS-1:0] enable_mask;
  } tpm_cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0]        now_ms;
    logic signed [POS_W-1:0] pedal_pos_a;
    logic signed [POS_W-1:0] pedal_pos_b;
    logic signed [POS_W-1:0] throttle_pos_a;
    logic signed [POS_W-1:0] throttle_pos_b;
    logic signed [POS_W-1:0] target_pos;
    logic [OK_W-1:0]         circuit_ok;
    logic                    brake_high;
    logic                    throttle_wide_open;
  } tpm_sample_t;

  // True when the absolute difference of the two positions is below the threshold.
  function automatic logic close_enough(input logic signed [POS_W-1:0] a,
                                        input logic signed [POS_W-1:0] b,
                                        input logic [THR_W-1:0]        thr);
    logic signed [POS_W:0] d;
    logic [POS_W:0]        m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? (~d + 1'b1) : d;
    return m < {{(POS_W+1-THR_W){1'b0}}, thr};
  endfunction

endpackage

`default_nettype wire

// ===== design/tpm_if.sv =====
// Valid/ready channel interfaces for samples and results.
// Depends on tpm_pkg.
`default_nettype none

interface tpm_in_if;
  import tpm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [NOW_W-1:0]        now_ms;
  logic signed [POS_W-1:0] pedal_pos_a;
  logic signed [POS_W-1:0] pedal_pos_b;
  logic signed [POS_W-1:0] throttle_pos_a;
  logic signed [POS_W-1:0] throttle_pos_b;
  logic signed [POS_W-1:0] target_pos;
  logic [OK_W-1:0]         circuit_ok;
  logic                    brake_high;
  logic                    throttle_wide_open;

  modport source (output valid, now_ms, pedal_pos_a, pedal_pos_b, throttle_pos_a,
                  throttle_pos_b, target_pos, circuit_ok, brake_high,
                  throttle_wide_open, input ready);
  modport sink (input valid, now_ms, pedal_pos_a, pedal_pos_b, throttle_pos_a,
                throttle_pos_b, target_pos, circuit_ok, brake_high,
                throttle_wide_open, output ready);
endinterface

interface tpm_out_if;
  import tpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [NUM_CHECKS-1:0] fault_bits;
  logic                  currently_valid;
  logic                  valid_all_time;

  modport source (output valid, fault_bits, currently_valid, valid_all_time,
                  input ready);
  modport sink (input valid, fault_bits, currently_valid, valid_all_time,
                output ready);
endinterface

`default_nettype wire

// ===== design/tpm_cfg_regs.sv =====
// Configuration register bank of the throttle plausibility monitor.
// Depends on tpm_pkg.
`default_nettype none

module tpm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tpm_pkg::tpm_cfg_t               cfg
);
  import tpm_pkg::*;

  tpm_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:     cfg_nxt.threshold     = cfg_wdata[THR_W-1:0];
        CFG_SENSOR_LIMIT:  cfg_nxt.sensor_limit  = cfg_wdata[NOW_W-1:0];
        CFG_TARGET_LIMIT:  cfg_nxt.target_limit  = cfg_wdata[NOW_W-1:0];
        CFG_BRAKE_LIMIT:   cfg_nxt.brake_limit   = cfg_wdata[NOW_W-1:0];
        CFG_STARTUP_GRACE: cfg_nxt.startup_grace = cfg_wdata[NOW_W-1:0];
        CFG_ENABLE_MASK:   cfg_nxt.enable_mask   = cfg_wdata[NUM_CHECKS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= 15'd1000;
      cfg_r.sensor_limit  <= 32'd100;
      cfg_r.target_limit  <= 32'd500;
      cfg_r.brake_limit   <= 32'd500;
      cfg_r.startup_grace <= 32'd1000;
      cfg_r.enable_mask   <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/tpm_lgt_mem.sv =====
// Last-good-time store: one 32-bit entry per check, registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on tpm_pkg.
`default_nettype none

module tpm_lgt_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [tpm_pkg::CHK_IDX_W-1:0]  rd_addr,
  output logic [tpm_pkg::NOW_W-1:0]      rd_data,
  input  logic                           wr_en,
  input  logic [tpm_pkg::CHK_IDX_W-1:0]  wr_addr,
  input  logic [tpm_pkg::NOW_W-1:0]      wr_data
);
  import tpm_pkg::*;

  logic [NOW_W-1:0]      mem [NUM_CHECKS];
  logic [NUM_CHECKS-1:0] vld_r;
  logic [NOW_W-1:0]      rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/throttle_plausibility_monitor_core.sv =====
// Top level of the throttle plausibility monitor.
// Depends on tpm_pkg, tpm_if, tpm_cfg_regs and tpm_lgt_mem.
//
// Samples enter on in_ch, one beat per sample; each produces exactly one result
// beat on out_ch with the fault bits, the masked current validity and the sticky
// validity latch. The user must write registers through cfg_we/cfg_index/cfg_wdata
// only while no sample is in flight; the block itself does not enforce this.
// A sequencer walks the nine checks in order through the single read and write
// port of the last-good-time memory: a read is issued for one check per cycle
// unless the pipeline stalls, and the judge stage behind it evaluates it and
// writes the new time back. A new sample is taken in the cycle its predecessor
// issues its last read, so a sample can enter before its predecessor's result is out.
// Within and across samples a read never targets the entry being written.
// Reset restores the register defaults, sets the validity latch and marks all
// last-good times as zero; no clearing pass is needed. When out_ch.ready is low
// the waiting result stays in the result register; the next sample runs through
// its first eight checks and then holds with its last check in the judge stage,
// and in_ch.ready then stays low until the waiting beat is taken.
`default_nettype none

module throttle_plausibility_monitor_core (
  input  logic                           clk,
  input  logic                           rst_n,
  tpm_in_if.sink                         in_ch,
  tpm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tpm_pkg::*;

  tpm_cfg_t cfg;

  tpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Issue stage.
  tpm_sample_t          ctx_r;
  logic                 busy_r, busy_nxt;
  logic [CHK_IDX_W-1:0] idx_r, idx_nxt;
  logic                 good_sel;
  logic [NOW_W-1:0]     limit_sel;
  logic                 grace;

  // Judge stage.
  logic                  s2_vld_r;
  logic [CHK_IDX_W-1:0]  s2_idx_r;
  logic [NOW_W-1:0]      s2_now_r;
  logic                  s2_good_r;
  logic [NOW_W-1:0]      s2_limit_r;
  logic                  s2_grace_r;
  logic                  s2_last_r;
  logic [NUM_CHECKS-2:0] acc_r;
  logic [NOW_W-1:0]      last_good;
  logic [NOW_W-1:0]      elapsed;
  logic                  fail;
  logic [NUM_CHECKS-1:0] faults;
  logic                  cur_valid;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [NUM_CHECKS-1:0] out_faults_r;
  logic                  out_cur_r;
  logic                  latch_r, latch_nxt;

  logic stall, in_acc, issue, out_load;

  assign stall    = s2_vld_r & s2_last_r & out_valid_r & ~out_ch.ready;
  assign in_ch.ready = ~stall & (~busy_r | (idx_r == CHK_LAST));
  assign in_acc   = in_ch.valid & in_ch.ready;
  assign issue    = busy_r & ~stall;
  assign out_load = s2_vld_r & s2_last_r & ~stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ctx_r.now_ms             <= in_ch.now_ms;
      ctx_r.pedal_pos_a        <= in_ch.pedal_pos_a;
      ctx_r.pedal_pos_b        <= in_ch.pedal_pos_b;
      ctx_r.throttle_pos_a     <= in_ch.throttle_pos_a;
      ctx_r.throttle_pos_b     <= in_ch.throttle_pos_b;
      ctx_r.target_pos         <= in_ch.target_pos;
      ctx_r.circuit_ok         <= in_ch.circuit_ok;
      ctx_r.brake_high         <= in_ch.brake_high;
      ctx_r.throttle_wide_open <= in_ch.throttle_wide_open;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      idx_nxt  = CHK_PEDAL_PAIR;
    end else if (issue) begin
      if (idx_r == CHK_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= CHK_PEDAL_PAIR;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_comb begin
    limit_sel = cfg.sensor_limit;
    case (idx_r)
      CHK_PEDAL_PAIR: begin
        good_sel = close_enough(ctx_r.pedal_pos_a, ctx_r.pedal_pos_b, cfg.threshold);
      end
      CHK_THROTTLE_PAIR: begin
        good_sel = close_enough(ctx_r.throttle_pos_a, ctx_r.throttle_pos_b,
                                cfg.threshold);
      end
      CHK_PEDAL_A_CIRC: good_sel = ctx_r.circuit_ok[0];
      CHK_PEDAL_B_CIRC: good_sel = ctx_r.circuit_ok[1];
      CHK_THR_A_CIRC:   good_sel = ctx_r.circuit_ok[2];
      CHK_THR_B_CIRC:   good_sel = ctx_r.circuit_ok[3];
      CHK_TARGET: begin
        good_sel  = close_enough(ctx_r.target_pos, ctx_r.throttle_pos_a, cfg.threshold);
        limit_sel = cfg.target_limit;
      end
      CHK_BRAKE_CIRC: good_sel = ctx_r.circuit_ok[4];
      CHK_BRAKE_THR: begin
        good_sel  = ~(ctx_r.brake_high & ctx_r.throttle_wide_open);
        limit_sel = cfg.brake_limit;
      end
      default: good_sel = 1'b1;
    endcase
  end

  assign grace = ctx_r.now_ms < cfg.startup_grace;

  tpm_lgt_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (issue),
    .rd_addr (idx_r),
    .rd_data (last_good),
    .wr_en   (s2_vld_r & ~stall & s2_good_r & ~s2_grace_r),
    .wr_addr (s2_idx_r),
    .wr_data (s2_now_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (!stall) begin
      s2_vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_idx_r   <= idx_r;
      s2_now_r   <= ctx_r.now_ms;
      s2_good_r  <= good_sel;
      s2_limit_r <= limit_sel;
      s2_grace_r <= grace;
      s2_last_r  <= (idx_r == CHK_LAST);
    end
  end

  assign elapsed   = s2_now_r - last_good;
  assign fail      = ~s2_good_r & ~s2_grace_r & (elapsed > s2_limit_r);
  assign faults    = {fail, acc_r};
  assign cur_valid = s2_grace_r | ((faults & cfg.enable_mask) == '0);

  always_ff @(posedge clk) begin
    if (s2_vld_r && !stall && !s2_last_r) begin
      acc_r[s2_idx_r[CHK_IDX_W-2:0]] <= fail;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    latch_nxt     = latch_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      latch_nxt     = s2_grace_r | (latch_r & cur_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      latch_r     <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      latch_r     <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_faults_r <= faults;
      out_cur_r    <= cur_valid;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fault_bits      = out_faults_r;
  assign out_ch.currently_valid = out_cur_r;
  assign out_ch.valid_all_time  = latch_r;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for throttle_plausibility_monitor_core: directed and random sensor samples.
// Predicts faults and validity per accepted beat and compares each result beat in order.
// Depends on tpm_pkg, tpm_if and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import tpm_pkg::*;

  typedef struct packed {
    logic [NUM_CHECKS-1:0] fault_bits;
    logic                  currently_valid;
    logic                  valid_all_time;
  } health_t;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic recv_hold;

  tpm_in_if  in_ch ();
  tpm_out_if out_ch ();

  throttle_plausibility_monitor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [THR_W-1:0]      thr_r;
  logic [NOW_W-1:0]      sensor_lim;
  logic [NOW_W-1:0]      target_lim;
  logic [NOW_W-1:0]      brake_lim;
  logic [NOW_W-1:0]      grace_r;
  logic [NUM_CHECKS-1:0] mask_r;
  logic [NOW_W-1:0]      good_since [NUM_CHECKS];
  logic                  latched_valid;

  health_t expected_health [$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  logic [NOW_W-1:0]      sim_now;
  logic [NUM_CHECKS-1:0] bad_episode;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL throttle_plausibility_monitor_core");
      $finish;
    end
  end

  task automatic reset_model();
    int k;
    thr_r         = 15'd1000;
    sensor_lim    = 32'd100;
    target_lim    = 32'd500;
    brake_lim     = 32'd500;
    grace_r       = 32'd1000;
    mask_r        = '1;
    latched_valid = 1'b1;
    for (k = 0; k < NUM_CHECKS; k++) good_since[k] = '0;
  endtask

  function automatic bit positions_agree(input logic signed [POS_W-1:0] a,
                                         input logic signed [POS_W-1:0] b);
    int gap;
    gap = int'(a) - int'(b);
    if (gap < 0) gap = -gap;
    return gap < int'(thr_r);
  endfunction

  task automatic predict_health(input tpm_sample_t s);
    logic [NUM_CHECKS-1:0] good;
    logic [NUM_CHECKS-1:0] faults;
    logic [NOW_W-1:0]      limit;
    health_t               h;
    int                    k;
    if (s.now_ms < grace_r) begin
      latched_valid     = 1'b1;
      h.fault_bits      = '0;
      h.currently_valid = 1'b1;
      h.valid_all_time  = 1'b1;
    end else begin
      good[CHK_PEDAL_PAIR]    = positions_agree(s.pedal_pos_a, s.pedal_pos_b);
      good[CHK_THROTTLE_PAIR] = positions_agree(s.throttle_pos_a, s.throttle_pos_b);
      good[CHK_PEDAL_A_CIRC]  = s.circuit_ok[0];
      good[CHK_PEDAL_B_CIRC]  = s.circuit_ok[1];
      good[CHK_THR_A_CIRC]    = s.circuit_ok[2];
      good[CHK_THR_B_CIRC]    = s.circuit_ok[3];
      good[CHK_TARGET]        = positions_agree(s.target_pos, s.throttle_pos_a);
      good[CHK_BRAKE_CIRC]    = s.circuit_ok[4];
      good[CHK_BRAKE_THR]     = !(s.brake_high && s.throttle_wide_open);
      for (k = 0; k < NUM_CHECKS; k++) begin
        if (k == CHK_TARGET) limit = target_lim;
        else if (k == CHK_BRAKE_THR) limit = brake_lim;
        else limit = sensor_lim;
        if (good[k]) begin
          good_since[k] = s.now_ms;
          faults[k] = 1'b0;
        end else begin
          faults[k] = (s.now_ms - good_since[k]) > limit;
        end
      end
      h.fault_bits      = faults;
      h.currently_valid = ((faults & mask_r) == '0);
      latched_valid     = latched_valid & h.currently_valid;
      h.valid_all_time  = latched_valid;
    end
    expected_health.push_back(h);
  endtask

  task automatic check_health();
    health_t want;
    if (expected_health.size() == 0) begin
      $error("result beat arrived with no sample waiting for it");
      fail_count++;
    end else begin
      want = expected_health.pop_front();
      if (out_ch.fault_bits !== want.fault_bits) begin
        $error("fault_bits: expected %h, got %h", want.fault_bits, out_ch.fault_bits);
        fail_count++;
      end
      if (out_ch.currently_valid !== want.currently_valid) begin
        $error("currently_valid: expected %b, got %b", want.currently_valid,
               out_ch.currently_valid);
        fail_count++;
      end
      if (out_ch.valid_all_time !== want.valid_all_time) begin
        $error("valid_all_time: expected %b, got %b", want.valid_all_time,
               out_ch.valid_all_time);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_health();
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic hold_results(input int cycles);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  task automatic send_sample(input tpm_sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid              <= 1'b1;
    in_ch.now_ms             <= s.now_ms;
    in_ch.pedal_pos_a        <= s.pedal_pos_a;
    in_ch.pedal_pos_b        <= s.pedal_pos_b;
    in_ch.throttle_pos_a     <= s.throttle_pos_a;
    in_ch.throttle_pos_b     <= s.throttle_pos_b;
    in_ch.target_pos         <= s.target_pos;
    in_ch.circuit_ok         <= s.circuit_ok;
    in_ch.brake_high         <= s.brake_high;
    in_ch.throttle_wide_open <= s.throttle_wide_open;
    do @(posedge clk); while (!in_ch.ready);
    predict_health(s);
  endtask

  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    while (expected_health.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:     thr_r = data[THR_W-1:0];
      CFG_SENSOR_LIMIT:  sensor_lim = data;
      CFG_TARGET_LIMIT:  target_lim = data;
      CFG_BRAKE_LIMIT:   brake_lim = data;
      CFG_STARTUP_GRACE: grace_r = data;
      CFG_ENABLE_MASK:   mask_r = data[NUM_CHECKS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic tpm_sample_t make_sample(input logic [NOW_W-1:0] now, input int pa,
                                              input int pb, input int ta, input int tb,
                                              input int tg, input logic [OK_W-1:0] ok,
                                              input logic brake, input logic wide);
    tpm_sample_t s;
    s.now_ms             = now;
    s.pedal_pos_a        = pa[POS_W-1:0];
    s.pedal_pos_b        = pb[POS_W-1:0];
    s.throttle_pos_a     = ta[POS_W-1:0];
    s.throttle_pos_b     = tb[POS_W-1:0];
    s.target_pos         = tg[POS_W-1:0];
    s.circuit_ok         = ok;
    s.brake_high         = brake;
    s.throttle_wide_open = wide;
    return s;
  endfunction

  function automatic tpm_sample_t bad_sample(input logic [NOW_W-1:0] now);
    return make_sample(now, 1000, 0, -20000, 20000, 20000, '0, 1'b1, 1'b1);
  endfunction

  function automatic tpm_sample_t good_sample(input logic [NOW_W-1:0] now);
    return make_sample(now, 0, 0, 0, 0, 0, '1, 1'b0, 1'b0);
  endfunction

  function automatic int random_pos();
    return int'($urandom_range(40000)) - 20000;
  endfunction

  function automatic int nearby_pos(input int a);
    int off;
    int b;
    off = (thr_r == 0) ? 0 : int'($urandom_range(int'(thr_r) - 1));
    b = $urandom_range(1) ? a + off : a - off;
    if (b > 20000) b = 20000;
    if (b < -20000) b = -20000;
    return b;
  endfunction

  function automatic logic [NOW_W-1:0] pick_limit();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return $urandom_range(300);
  endfunction

  function automatic tpm_sample_t next_sample();
    tpm_sample_t s;
    int roll;
    int pa;
    int ta;
    int k;
    roll = $urandom_range(99);
    if (roll < 80) sim_now += $urandom_range(40, 1);
    else if (roll < 93) sim_now += $urandom_range(700, 41);
    else if (roll < 97) sim_now = $urandom();
    else sim_now = $urandom_range(1500);
    for (k = 0; k < NUM_CHECKS; k++)
      if ($urandom_range(99) < 8) bad_episode[k] = ~bad_episode[k];
    if ($urandom_range(99) < 10) begin
      return make_sample(sim_now, random_pos(), random_pos(), random_pos(), random_pos(),
                         random_pos(), OK_W'($urandom_range(31)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
    end
    pa = random_pos();
    ta = random_pos();
    s = make_sample(sim_now, pa,
                    bad_episode[CHK_PEDAL_PAIR] ? random_pos() : nearby_pos(pa),
                    ta,
                    bad_episode[CHK_THROTTLE_PAIR] ? random_pos() : nearby_pos(ta),
                    bad_episode[CHK_TARGET] ? random_pos() : nearby_pos(ta),
                    ~{bad_episode[CHK_BRAKE_CIRC], bad_episode[CHK_THR_B_CIRC],
                      bad_episode[CHK_THR_A_CIRC], bad_episode[CHK_PEDAL_B_CIRC],
                      bad_episode[CHK_PEDAL_A_CIRC]},
                    1'b0, 1'b0);
    if (bad_episode[CHK_BRAKE_THR]) {s.brake_high, s.throttle_wide_open} = 2'b11;
    else {s.brake_high, s.throttle_wide_open} = 2'($urandom_range(2));
    return s;
  endfunction

  task automatic test_startup_grace();
    send_sample(bad_sample(32'd0));
    send_sample(bad_sample(32'd999));
    send_sample(good_sample(32'd1000));
  endtask

  task automatic test_time_limits();
    send_sample(bad_sample(32'd1100));
    send_sample(bad_sample(32'd1101));
    send_sample(bad_sample(32'd1500));
    send_sample(bad_sample(32'd1501));
    send_sample(make_sample(32'd1502, 20000, 20000, -20000, -20000, -19001, '1, 1'b1, 1'b0));
    send_sample(make_sample(32'd1503, -20000, -19001, 20000, 19001, 20000, '1, 1'b0, 1'b1));
  endtask

  task automatic test_enable_mask();
    wait_until_idle();
    write_reg(CFG_ENABLE_MASK, '0);
    send_sample(bad_sample(32'd2000));
    wait_until_idle();
    write_reg(CFG_ENABLE_MASK, 32'd1 << CHK_BRAKE_THR);
    send_sample(make_sample(32'd2100, 0, 0, 0, 0, 0, '1, 1'b1, 1'b1));
    wait_until_idle();
    write_reg(CFG_ENABLE_MASK, ~(32'd1 << CHK_BRAKE_THR));
    send_sample(make_sample(32'd2101, 0, 0, 0, 0, 0, '1, 1'b1, 1'b1));
  endtask

  task automatic test_wrap_and_grace();
    wait_until_idle();
    write_reg(CFG_ENABLE_MASK, '1);
    write_reg(CFG_STARTUP_GRACE, '0);
    send_sample(good_sample(32'hFFFF_FFF0));
    send_sample(bad_sample(32'h0000_0010));
    send_sample(bad_sample(32'h0000_0060));
    wait_until_idle();
    write_reg(CFG_STARTUP_GRACE, '1);
    send_sample(bad_sample(32'd5));
    send_sample(bad_sample(32'hFFFF_FFFF));
  endtask

  task automatic test_config_extremes();
    wait_until_idle();
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_SENSOR_LIMIT, '0);
    write_reg(CFG_TARGET_LIMIT, '0);
    write_reg(CFG_BRAKE_LIMIT, '0);
    write_reg(CFG_STARTUP_GRACE, '0);
    write_reg(CFG_UNUSED_LO, '1);
    write_reg(CFG_UNUSED_HI, '0);
    send_sample(good_sample(32'd200));
    send_sample(good_sample(32'd200));
    wait_until_idle();
    write_reg(CFG_THRESHOLD, 32'd20000);
    write_reg(CFG_SENSOR_LIMIT, '1);
    write_reg(CFG_TARGET_LIMIT, '1);
    write_reg(CFG_BRAKE_LIMIT, '1);
    send_sample(bad_sample(32'd300));
    send_sample(make_sample(32'd301, 19999, 0, -20000, -1, 0, '1, 1'b0, 1'b0));
  endtask

  task automatic test_backpressure();
    wait_until_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      hold_results(250);
      repeat (40) send_sample(next_sample());
    join
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    wait_until_idle();
    write_reg(CFG_THRESHOLD, $urandom_range(1) ? $urandom_range(20000) : $urandom_range(2000, 50));
    write_reg(CFG_SENSOR_LIMIT, pick_limit());
    write_reg(CFG_TARGET_LIMIT, pick_limit());
    write_reg(CFG_BRAKE_LIMIT, pick_limit());
    write_reg(CFG_STARTUP_GRACE, $urandom_range(1500));
    write_reg(CFG_ENABLE_MASK, $urandom_range(511));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_sample(next_sample());
  endtask

  initial begin
    rst_n                    = 1'b0;
    recv_hold                = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = CFG_THRESHOLD;
    cfg_wdata                = '0;
    in_ch.valid              = 1'b0;
    in_ch.now_ms             = '0;
    in_ch.pedal_pos_a        = '0;
    in_ch.pedal_pos_b        = '0;
    in_ch.throttle_pos_a     = '0;
    in_ch.throttle_pos_b     = '0;
    in_ch.target_pos         = '0;
    in_ch.circuit_ok         = '0;
    in_ch.brake_high         = 1'b0;
    in_ch.throttle_wide_open = 1'b0;
    out_ch.ready             = 1'b0;
    sim_now                  = '0;
    bad_episode              = '0;
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_startup_grace();
    test_time_limits();
    test_enable_mask();
    test_wrap_and_grace();
    test_config_extremes();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 61, 0);
    test_backpressure();
    test_random_traffic(350, 0, 61);
    test_random_traffic(350, 13, 13);

    wait_until_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_health.size() == 0) begin
      $display("PASS throttle_plausibility_monitor_core");
    end else begin
      $display("FAIL throttle_plausibility_monitor_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tpm_pkg.sv
design/tpm_if.sv
design/tpm_cfg_regs.sv
design/tpm_lgt_mem.sv
design/throttle_plausibility_monitor_core.sv
bench/tb_top.sv
